// ===== src/utf8v_pkg.sv =====
// utf8v_pkg: shared types, byte class codes and the lead byte classifier
// for the utf-8 sequence validator; no dependencies
package utf8v_pkg;

    localparam int ByteW    = 8;
    localparam int PendW    = 3;
    localparam int FifoDepth = 2;
    localparam int FifoPtrW = 1;
    localparam int FifoCntW = 2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CONT = 2'd1;
    localparam logic [1:0] KIND_LEAD = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PendW-1:0] lead_len;
        logic             last;
    } item_t;

    function automatic item_t classify(input logic [ByteW-1:0] b, input logic no_byte,
                                       input logic last);
        item_t it;
        it.last     = last;
        it.lead_len = '0;
        it.kind     = KIND_LEAD;
        if (no_byte)
        begin
            it.kind = KIND_NONE;
        end
        else if (b[7] == 1'b0)
        begin
            it.lead_len = 3'd0;
        end
        else if (b[7:6] == 2'b10)
        begin
            it.kind = KIND_CONT;
        end
        else if (b[7:5] == 3'b110)
        begin
            it.lead_len = 3'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            it.lead_len = 3'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            it.lead_len = 3'd3;
        end
        else if (b[7:2] == 6'b111110)
        begin
            it.lead_len = 3'd4;
        end
        else if (b[7:1] == 7'b1111110)
        begin
            it.lead_len = 3'd5;
        end
        else
        begin
            it.kind = KIND_BAD;
        end
        return it;
    endfunction

endpackage

// ===== src/utf8v_front.sv =====
// utf8v_front: accepts input items and registers their byte class
// depends on utf8v_pkg
module utf8v_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [utf8v_pkg::ByteW-1:0]   in_byte,
    input  logic                          in_no_byte,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output utf8v_pkg::item_t              out_item
);
    import utf8v_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= classify(in_byte, in_no_byte, in_last);
        end
    end

endmodule

// ===== src/utf8v_fifo.sv =====
// utf8v_fifo: two-entry queue of classified items between front and back
// depends on utf8v_pkg
module utf8v_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  utf8v_pkg::item_t      in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8v_pkg::item_t      out_item
);
    import utf8v_pkg::*;

    item_t                 mem_reg [FifoDepth];
    logic [FifoPtrW-1:0]   wr_ptr_reg;
    logic [FifoPtrW-1:0]   wr_ptr_next;
    logic [FifoPtrW-1:0]   rd_ptr_reg;
    logic [FifoPtrW-1:0]   rd_ptr_next;
    logic [FifoCntW-1:0]   count_reg;
    logic [FifoCntW-1:0]   count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg != FifoCntW'(FifoDepth));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FifoCntW'(FifoDepth))
        else $error("fifo count over depth");

    // pointers differ by exactly the count modulo depth
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FifoPtrW-1:0])
        else $error("fifo pointers disagree with count");

endmodule

// ===== src/utf8v_back.sv =====
// utf8v_back: sequence state update and result register
// depends on utf8v_pkg
module utf8v_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  utf8v_pkg::item_t      in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_res
);
    import utf8v_pkg::*;

    logic [PendW-1:0] pend_reg;
    logic [PendW-1:0] pend_next;
    logic             failed_reg;
    logic             failed_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             res_reg;
    logic [PendW-1:0] pend_upd;
    logic             failed_upd;
    logic             take;

    // non-last items never need the result register
    assign in_ready  = !in_item.last || !res_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        pend_upd   = pend_reg;
        failed_upd = failed_reg;
        if (in_item.kind != KIND_NONE && !failed_reg)
        begin
            if (pend_reg != '0)
            begin
                if (in_item.kind == KIND_CONT)
                begin
                    pend_upd = pend_reg - 1'b1;
                end
                else
                begin
                    failed_upd = 1'b1;
                end
            end
            else if (in_item.kind == KIND_LEAD)
            begin
                pend_upd = in_item.lead_len;
            end
            else
            begin
                failed_upd = 1'b1;
            end
        end

        pend_next      = pend_reg;
        failed_next    = failed_reg;
        res_valid_next = res_valid_reg && !out_ready;
        if (take)
        begin
            pend_next   = in_item.last ? '0 : pend_upd;
            failed_next = in_item.last ? 1'b0 : failed_upd;
            if (in_item.last)
            begin
                res_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            failed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            failed_reg    <= failed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_item.last)
        begin
            res_reg <= !failed_upd && (pend_upd == '0);
        end
    end

    // at most five continuations are ever owed
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd5)
        else $error("pending count out of range");

    // a last item leaves the state clear for the next string
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_item.last |=> pend_reg == '0 && !failed_reg)
        else $error("state not cleared after last item");

    // a result appears only after a last item was taken
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(take && in_item.last))
        else $error("result without last item");

    // a failed string stays failed, with its pending count frozen, until its last item
    a_failed_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && take && !in_item.last |=> failed_reg && $stable(pend_reg))
        else $error("state changed after failure");

endmodule

// ===== src/utf8_sequence_validator.sv =====
// utf8_sequence_validator: top level, front classifier, item queue, back checker
// depends on utf8v_pkg, utf8v_front, utf8v_fifo, utf8v_back
//
//  channel  | direction | tdata           | tuser    | tlast
//  s_axis   | in        | [7:0] data_byte | no_byte  | is_last
//  m_axis   | out       | [0] valid_res   | -        | -
//
// one item per cycle sustained unless a waiting result holds back a last item; a last item passes the front
// register and a queue entry before its result is registered; front register, 2-entry queue and result register
// each stall on their own; only a waiting result blocks, and only a last item behind it
// reset clears the valid, pointer, count and sequence state; the first string starts right after reset
module utf8_sequence_validator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] no_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] valid_res, [7:1] zero
);
    import utf8v_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;
    logic  res;

    utf8v_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_no_byte (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_item   (fr_item)
    );

    utf8v_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    utf8v_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {7'b0, res};

endmodule
